// File: rtl/dtp_pkg.sv
// Shared types and constants for the display transform pixel pipeline.
package dtp_pkg;

   // Widths of the pixel fields.
   localparam int IN_W     = 20;
   localparam int CODE_W   = 12;
   localparam int GAIN_W   = 16;
   localparam int ACC_W    = 38;

   // Largest output code, which stands for 1.0.
   localparam logic [CODE_W-1:0] CODE_MAX = {CODE_W{1'b1}};

   // Reset value of the white gain register (1.0 in Q4.12).
   localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd4096;

   // Color matrix coefficients in Q2.14, row by row.
   localparam logic signed [15:0] M_RR = 16'sd17200;
   localparam logic signed [15:0] M_RB = -16'sd2;
   localparam logic signed [15:0] M_GR = -16'sd8125;
   localparam logic signed [15:0] M_GG = 16'sd22500;
   localparam logic signed [15:0] M_GB = 16'sd1610;
   localparam logic signed [15:0] M_BB = 16'sd16241;

   // Number of register stages inside one channel.
   localparam int CH_LAT = 108;

   typedef struct packed {
      logic signed [IN_W-1:0] red_in;
      logic signed [IN_W-1:0] green_in;
      logic signed [IN_W-1:0] blue_in;
   } req_type;

   typedef struct packed {
      logic [CODE_W-1:0] red_out;
      logic [CODE_W-1:0] green_out;
      logic [CODE_W-1:0] blue_out;
   } rsp_type;

   // Which encoding segment a channel value falls into.
   typedef enum logic [1:0] {
      MODE_LIN,
      MODE_POW,
      MODE_SAT
   } mode_type;

endpackage

// File: rtl/dtp_channel.sv
// One color channel: soft clip, white gain and sRGB encode, fully pipelined.
module dtp_channel
   import dtp_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  logic signed [ACC_W-1:0]  acc,
   input  logic [GAIN_W-1:0]        white_gain,
   output logic                     out_valid,
   output logic [CODE_W-1:0]        code
);

   // Valid bits travel alongside every stage.
   logic [CH_LAT-1:0] vld_ff;
   logic [CH_LAT-1:0] vld_in;

   assign vld_in    = {vld_ff[CH_LAT-2:0], in_valid};
   assign out_valid = vld_ff[CH_LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // Round the matrix sum to Q.12; a sum that is not positive gives zero.
   logic signed [ACC_W-1:0] acc_rnd;
   logic [20:0]             x_ff;
   logic [20:0]             x_in;

   assign acc_rnd = acc + 38'sd8192;
   assign x_in    = (acc > 0) ? acc_rnd[34:14] : '0;

   always_ff @(posedge clock) begin
      x_ff <= x_in;
   end

   // Divider setup: numerator carries half the divisor for rounding.
   logic [21:0] dd_ff [0:17];
   logic [37:0] rem_ff [0:17];
   logic [16:0] q_ff [0:17];
   logic [21:0] d_in;

   assign d_in = {1'b0, x_ff} + 22'd4096;

   always_ff @(posedge clock) begin
      dd_ff[0]  <= d_in;
      rem_ff[0] <= {1'b0, x_ff, 16'b0} + {17'b0, d_in[21:1]};
      q_ff[0]   <= '0;
   end

   // Restoring division, one quotient bit per stage, most significant first.
   for (genvar i = 0; i < 17; i++) begin : g_div
      localparam int K = 16 - i;
      logic [37:0] sub;
      logic        ge;

      assign sub = {16'b0, dd_ff[i]} << K;
      assign ge  = (rem_ff[i] >= sub);

      always_ff @(posedge clock) begin
         dd_ff[i+1]  <= dd_ff[i];
         rem_ff[i+1] <= ge ? (rem_ff[i] - sub) : rem_ff[i];
         q_ff[i+1]   <= q_ff[i] | ({16'b0, ge} << K);
      end
   end

   // Cap the soft clip and apply the white gain.
   logic [15:0] t_cap;
   logic [31:0] prod_ff;

   assign t_cap = q_ff[17][16] ? 16'hFFFF : q_ff[17][15:0];

   always_ff @(posedge clock) begin
      prod_ff <= t_cap * white_gain;
   end

   // Round the gain product and pick the encoding segment.
   logic [32:0] ysum;
   logic [15:0] y16;
   mode_type    ymode_in;
   mode_type    ymode_ff;
   logic [15:0] y_ff;
   logic [16:0] v_ff;

   assign ysum = {1'b0, prod_ff} + 33'd2048;
   assign y16  = ysum[27:12];

   always_comb begin
      if (|ysum[32:28]) begin
         ymode_in = MODE_SAT;
      end else if (y16 <= 16'd205) begin
         ymode_in = MODE_LIN;
      end else begin
         ymode_in = MODE_POW;
      end
   end

   always_ff @(posedge clock) begin
      ymode_ff <= ymode_in;
      y_ff     <= y16;
      v_ff     <= 17'(y16[7:0]) * 17'd323 + 17'd200;
   end

   // Linear segment: (y*323 + 200) / 400 by reciprocal multiply.
   logic [34:0] lin_prod;
   logic [20:0] cr_ff [0:21];
   logic [41:0] csq_ff [0:21];
   logic [47:0] crem_ff [0:21];
   logic [15:0] cy_ff [0:21];
   mode_type    cmode_ff [0:21];
   logic [8:0]  clin_ff [0:21];

   assign lin_prod = v_ff * 18'd167773;

   always_ff @(posedge clock) begin
      cr_ff[0]    <= '0;
      csq_ff[0]   <= '0;
      crem_ff[0]  <= '0;
      cy_ff[0]    <= y_ff;
      cmode_ff[0] <= ymode_ff;
      clin_ff[0]  <= lin_prod[34:26];
   end

   // Cube root of y in Q0.21, three radicand bits per stage.
   for (genvar i = 0; i < 21; i++) begin : g_cbrt
      localparam int G = 20 - i;
      logic [62:0] radicand;
      logic [47:0] cand;
      logic [47:0] tst;
      logic        ge;

      assign radicand = {cy_ff[i], 47'b0};
      assign cand     = {crem_ff[i][44:0], radicand[3*G+2 -: 3]};
      assign tst      = ({6'b0, csq_ff[i]} << 3) + ({6'b0, csq_ff[i]} << 2)
                      + ({27'b0, cr_ff[i]} << 2) + ({27'b0, cr_ff[i]} << 1) + 48'd1;
      assign ge       = (cand >= tst);

      always_ff @(posedge clock) begin
         cr_ff[i+1]    <= {cr_ff[i][19:0], ge};
         csq_ff[i+1]   <= ge ? ((csq_ff[i] << 2) + ({21'b0, cr_ff[i]} << 2) + 42'd1)
                             : (csq_ff[i] << 2);
         crem_ff[i+1]  <= ge ? (cand - tst) : cand;
         cy_ff[i+1]    <= cy_ff[i];
         cmode_ff[i+1] <= cmode_ff[i];
         clin_ff[i+1]  <= clin_ff[i];
      end
   end

   // First square root: s = sqrt(c) in Q0.31, two radicand bits per stage.
   logic [30:0] s1r_ff [1:31];
   logic [33:0] s1rem_ff [1:31];
   logic [20:0] s1c_ff [1:31];
   mode_type    s1mode_ff [1:31];
   logic [8:0]  s1lin_ff [1:31];

   for (genvar i = 0; i < 31; i++) begin : g_sqrt1
      localparam int G = 30 - i;
      logic [30:0] r_cur;
      logic [33:0] rem_cur;
      logic [20:0] c_cur;
      mode_type    mode_cur;
      logic [8:0]  lin_cur;
      logic [61:0] radicand;
      logic [33:0] cand;
      logic [33:0] tst;
      logic        ge;

      if (i == 0) begin : g_first
         assign r_cur    = '0;
         assign rem_cur  = '0;
         assign c_cur    = cr_ff[21];
         assign mode_cur = cmode_ff[21];
         assign lin_cur  = clin_ff[21];
      end else begin : g_next
         assign r_cur    = s1r_ff[i];
         assign rem_cur  = s1rem_ff[i];
         assign c_cur    = s1c_ff[i];
         assign mode_cur = s1mode_ff[i];
         assign lin_cur  = s1lin_ff[i];
      end

      assign radicand = {c_cur, 41'b0};
      assign cand     = {rem_cur[31:0], radicand[2*G+1 -: 2]};
      assign tst      = {1'b0, r_cur, 2'b01};
      assign ge       = (cand >= tst);

      always_ff @(posedge clock) begin
         s1r_ff[i+1]    <= {r_cur[29:0], ge};
         s1rem_ff[i+1]  <= ge ? (cand - tst) : cand;
         s1c_ff[i+1]    <= c_cur;
         s1mode_ff[i+1] <= mode_cur;
         s1lin_ff[i+1]  <= lin_cur;
      end
   end

   // Second square root: f = sqrt(s) in Q0.31, with s carried along.
   logic [30:0] s2r_ff [1:31];
   logic [33:0] s2rem_ff [1:31];
   logic [30:0] s2s_ff [1:31];
   logic [20:0] s2c_ff [1:31];
   mode_type    s2mode_ff [1:31];
   logic [8:0]  s2lin_ff [1:31];

   for (genvar i = 0; i < 31; i++) begin : g_sqrt2
      localparam int G = 30 - i;
      logic [30:0] r_cur;
      logic [33:0] rem_cur;
      logic [30:0] s_cur;
      logic [20:0] c_cur;
      mode_type    mode_cur;
      logic [8:0]  lin_cur;
      logic [61:0] radicand;
      logic [33:0] cand;
      logic [33:0] tst;
      logic        ge;

      if (i == 0) begin : g_first
         assign r_cur    = '0;
         assign rem_cur  = '0;
         assign s_cur    = s1r_ff[31];
         assign c_cur    = s1c_ff[31];
         assign mode_cur = s1mode_ff[31];
         assign lin_cur  = s1lin_ff[31];
      end else begin : g_next
         assign r_cur    = s2r_ff[i];
         assign rem_cur  = s2rem_ff[i];
         assign s_cur    = s2s_ff[i];
         assign c_cur    = s2c_ff[i];
         assign mode_cur = s2mode_ff[i];
         assign lin_cur  = s2lin_ff[i];
      end

      assign radicand = {s_cur, 31'b0};
      assign cand     = {rem_cur[31:0], radicand[2*G+1 -: 2]};
      assign tst      = {1'b0, r_cur, 2'b01};
      assign ge       = (cand >= tst);

      always_ff @(posedge clock) begin
         s2r_ff[i+1]    <= {r_cur[29:0], ge};
         s2rem_ff[i+1]  <= ge ? (cand - tst) : cand;
         s2s_ff[i+1]    <= s_cur;
         s2c_ff[i+1]    <= c_cur;
         s2mode_ff[i+1] <= mode_cur;
         s2lin_ff[i+1]  <= lin_cur;
      end
   end

   // Power product z = c * f in Q0.52.
   logic [51:0] z_ff;
   mode_type    zmode_ff;
   logic [8:0]  zlin_ff;

   always_ff @(posedge clock) begin
      z_ff     <= s2c_ff[31] * s2r_ff[31];
      zmode_ff <= s2mode_ff[31];
      zlin_ff  <= s2lin_ff[31];
   end

   // Scale by 1.055, subtract 0.055 and fold in the output rounding.
   logic [62:0]        a_prod;
   logic signed [64:0] w_sum;
   logic [23:0]        wq_ff;
   mode_type           wmode_ff;
   logic [8:0]         wlin_ff;

   assign a_prod = z_ff * 11'd1055;
   assign w_sum  = $signed({2'b0, a_prod}) + $signed(65'd1000 << 39)
                 - $signed(65'd55 << 52);

   always_ff @(posedge clock) begin
      wq_ff    <= w_sum[64] ? '0 : w_sum[63:40];
      wmode_ff <= zmode_ff;
      wlin_ff  <= zlin_ff;
   end

   // Divide by 1000 through a reciprocal multiply and select the code.
   logic [47:0]       pq_prod;
   logic [14:0]       pow_code;
   logic [CODE_W-1:0] code_in;
   logic [CODE_W-1:0] code_ff;

   assign pq_prod  = wq_ff * 24'd8589935;
   assign pow_code = pq_prod[47:33];

   always_comb begin
      case (wmode_ff)
         MODE_SAT: code_in = CODE_MAX;
         MODE_LIN: code_in = {3'b0, wlin_ff};
         default:  code_in = (pow_code > 15'(CODE_MAX)) ? CODE_MAX : pow_code[CODE_W-1:0];
      endcase
   end

   always_ff @(posedge clock) begin
      code_ff <= code_in;
   end

   assign code = code_ff;

`ifndef SYNTHESIS
   // The running square tracks the cube root digits.
   a_cbrt_square: assert property (@(posedge clock) disable iff (reset)
      vld_ff[42] |-> (csq_ff[21] == 42'(cr_ff[21]) * 42'(cr_ff[21])))
      else $error("cube root square out of step");

   // The cube root remainder stays below the next cube step.
   a_cbrt_rem: assert property (@(posedge clock) disable iff (reset)
      vld_ff[42] |-> (crem_ff[21] <= ({6'b0, csq_ff[21]} * 3 + {27'b0, cr_ff[21]} * 3)))
      else $error("cube root remainder too large");

   // The first square root remainder never exceeds twice the root.
   a_sqrt_rem: assert property (@(posedge clock) disable iff (reset)
      vld_ff[73] |-> (s1rem_ff[31] <= {2'b0, s1r_ff[31], 1'b0}))
      else $error("square root remainder too large");
`endif

endmodule

// File: rtl/display_transform_pixel.sv
// Top level of the display transform: color matrix and three channel pipelines.
//
// Usage:
//   A pixel request is taken at every rising clock edge where start is high
//   and busy is low; busy is always low, so one request is taken per cycle.
//   req_data carries the linear red, green and blue values in signed Q8.12.
//   Each result appears on rsp_data for exactly one cycle with rsp_valid high,
//   in request order. Throughput is one pixel per cycle: the color matrix takes
//   two stages, and each channel is a 108 stage pipeline whose depth is set by
//   the soft clip divider (17 stages), the cube root (21) and the two square
//   roots (31 each). The receiver cannot stall; every result is taken in the
//   cycle it is shown. The white gain register is written with csr_we and
//   csr_wdata; the user must write it only while no request is in flight, which
//   the block does not enforce; it takes effect for requests taken afterwards.
//   A synchronous reset empties the pipeline and sets the white gain to 1.0.
module display_transform_pixel
   import dtp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  req_type           req_data,
   input  logic              csr_we,
   input  logic [GAIN_W-1:0] csr_wdata,
   output logic              rsp_valid,
   output rsp_type           rsp_data
);

   // The pipeline never blocks a request.
   assign busy = 1'b0;

   // White gain register.
   logic [GAIN_W-1:0] gain_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= GAIN_RESET;
      end else if (csr_we) begin
         gain_ff <= csr_wdata;
      end
   end

   // Matrix stage one: the nonzero products.
   logic signed [35:0] p_rr_ff, p_rb_ff, p_gr_ff, p_gg_ff, p_gb_ff, p_bb_ff;
   logic               v1_ff;

   always_ff @(posedge clock) begin
      p_rr_ff <= req_data.red_in   * M_RR;
      p_rb_ff <= req_data.blue_in  * M_RB;
      p_gr_ff <= req_data.red_in   * M_GR;
      p_gg_ff <= req_data.green_in * M_GG;
      p_gb_ff <= req_data.blue_in  * M_GB;
      p_bb_ff <= req_data.blue_in  * M_BB;
   end

   // Matrix stage two: row sums.
   logic signed [ACC_W-1:0] acc_r_ff, acc_g_ff, acc_b_ff;
   logic                    v2_ff;

   always_ff @(posedge clock) begin
      acc_r_ff <= ACC_W'(p_rr_ff) + ACC_W'(p_rb_ff);
      acc_g_ff <= ACC_W'(p_gr_ff) + ACC_W'(p_gg_ff) + ACC_W'(p_gb_ff);
      acc_b_ff <= ACC_W'(p_bb_ff);
   end

   // Valid bits for the matrix stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= start & ~busy;
         v2_ff <= v1_ff;
      end
   end

   // Per channel transform and encode.
   logic red_valid;
   logic green_valid;
   logic blue_valid;

   dtp_channel u_red (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (v2_ff),
      .acc        (acc_r_ff),
      .white_gain (gain_ff),
      .out_valid  (red_valid),
      .code       (rsp_data.red_out)
   );

   dtp_channel u_green (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (v2_ff),
      .acc        (acc_g_ff),
      .white_gain (gain_ff),
      .out_valid  (green_valid),
      .code       (rsp_data.green_out)
   );

   dtp_channel u_blue (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (v2_ff),
      .acc        (acc_b_ff),
      .white_gain (gain_ff),
      .out_valid  (blue_valid),
      .code       (rsp_data.blue_out)
   );

   // The three channels run in lockstep.
   assign rsp_valid = red_valid & green_valid & blue_valid;

endmodule

// File: bench/tb_display_transform_pixel.sv
// Self-checking testbench for the display transform pixel pipeline.
`timescale 1ns / 1ps

module tb_display_transform_pixel;
   import dtp_pkg::*;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   req_type           req_data = '0;
   logic              csr_we = 1'b0;
   logic [GAIN_W-1:0] csr_wdata = '0;
   logic              rsp_valid;
   rsp_type           rsp_data;

   // Requests waiting to be driven and pixels expected back, in order.
   req_type pixel_queue[$];
   rsp_type expected_pixels[$];

   logic [GAIN_W-1:0] gain_model = GAIN_RESET;
   int unsigned       sender_idle_pct = 26;
   int unsigned       mismatch_count = 0;
   int unsigned       unexpected_count = 0;
   int unsigned       pixels_sent = 0;
   int unsigned       pixels_checked = 0;

   display_transform_pixel dut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .csr_we   (csr_we),
      .csr_wdata(csr_wdata),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Floor square root of a value below 2^64.
   function automatic longint unsigned floor_sqrt(input longint unsigned n);
      longint unsigned r;
      longint unsigned c;
      r = 0;
      for (int b = 31; b >= 0; b--) begin
         c = r | (64'd1 << b);
         if (c * c <= n) r = c;
      end
      return r;
   endfunction

   // Floor cube root of a value below 2^63.
   function automatic longint unsigned floor_cbrt(input longint unsigned n);
      longint unsigned r;
      longint unsigned c;
      r = 0;
      for (int b = 20; b >= 0; b--) begin
         c = r | (64'd1 << b);
         if (c * c * c <= n) r = c;
      end
      return r;
   endfunction

   // sRGB encoding of a gained Q0.16 value into a 12-bit code.
   function automatic logic [CODE_W-1:0] srgb_code(input longint unsigned y);
      longint unsigned code;
      longint unsigned cr;
      longint unsigned s;
      longint unsigned f;
      longint unsigned a;
      longint unsigned off;
      longint unsigned m;
      if (y > 65535) return CODE_MAX;
      if (y <= 205) begin
         code = (y * 1292 * 4096 + 50 * 65536) / (100 * 65536);
      end else begin
         cr = floor_cbrt(y << 47);
         s = floor_sqrt(cr << 41);
         f = floor_sqrt(s << 31);
         a = 1055 * (cr * f);
         off = 64'd55 << 52;
         m = (a > off) ? (a - off) / 1000 : 0;
         code = (m + (64'd1 << (51 - CODE_W))) >> (52 - CODE_W);
      end
      return (code > CODE_MAX) ? CODE_MAX : code[CODE_W-1:0];
   endfunction

   // One channel after the matrix: clamp, soft clip, white gain, encode.
   function automatic logic [CODE_W-1:0] channel_code(input longint acc);
      longint unsigned x;
      longint unsigned d;
      longint unsigned t;
      longint unsigned y;
      if (acc <= 0) return '0;
      x = (longint'(acc) + 8192) >>> 14;
      d = x + 4096;
      t = ((x << 16) + d / 2) / d;
      if (t > 65535) t = 65535;
      y = (t * gain_model + 2048) >> 12;
      return srgb_code(y);
   endfunction

   // Expected display pixel for one linear pixel.
   function automatic rsp_type display_pixel(input req_type p);
      longint r;
      longint g;
      longint b;
      rsp_type o;
      r = p.red_in;
      g = p.green_in;
      b = p.blue_in;
      o.red_out   = channel_code(longint'(M_RR) * r + longint'(M_RB) * b);
      o.green_out = channel_code(longint'(M_GR) * r + longint'(M_GG) * g
                                 + longint'(M_GB) * b);
      o.blue_out  = channel_code(longint'(M_BB) * b);
      return o;
   endfunction

   // Driver: record each accepted request, then present the next one.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            expected_pixels.push_back(display_pixel(req_data));
            pixels_sent++;
         end
         if ((!start || !busy) ) begin
            if (pixel_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               start <= 1'b1;
               req_data <= pixel_queue.pop_front();
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Monitor: compare each result with the oldest expected pixel.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (expected_pixels.size() == 0) begin
            unexpected_count++;
            $display("unexpected result %h", rsp_data);
         end else begin
            want = expected_pixels.pop_front();
            pixels_checked++;
            if (rsp_data.red_out !== want.red_out || rsp_data.green_out !== want.green_out
                || rsp_data.blue_out !== want.blue_out) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected r=%0d g=%0d b=%0d got r=%0d g=%0d b=%0d",
                           want.red_out, want.green_out, want.blue_out,
                           rsp_data.red_out, rsp_data.green_out, rsp_data.blue_out);
            end
         end
      end
   end

   function automatic req_type make_pixel(input int r, input int g, input int b);
      req_type p;
      p.red_in = IN_W'(r);
      p.green_in = IN_W'(g);
      p.blue_in = IN_W'(b);
      return p;
   endfunction

   // One random channel value, mostly in ranges where the curve bends.
   function automatic int random_channel();
      case ($urandom_range(3))
         0: return int'($urandom_range(0, 1048575)) - 524288;
         1: return int'($urandom_range(0, 40));
         2: return int'($urandom_range(0, 16384)) - 1024;
         default: return int'($urandom_range(0, 131072));
      endcase
   endfunction

   task automatic queue_random(input int count);
      for (int i = 0; i < count; i++)
         pixel_queue.push_back(make_pixel(random_channel(), random_channel(),
                                          random_channel()));
   endtask

   // Let every request drain through the pipeline.
   task automatic wait_drain();
      while (pixel_queue.size() != 0 || start || expected_pixels.size() != 0)
         @(posedge clock);
      repeat (120) @(posedge clock);
   endtask

   task automatic write_gain(input logic [GAIN_W-1:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      gain_model = value;
   endtask

   // Phases of stimulus, with gain changes only while the pipeline is empty.
   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed pixels at the reset gain: extremes, negatives, both segments.
      pixel_queue.push_back(make_pixel(0, 0, 0));
      pixel_queue.push_back(make_pixel(524287, 524287, 524287));
      pixel_queue.push_back(make_pixel(-524288, -524288, -524288));
      pixel_queue.push_back(make_pixel(524287, -524288, 0));
      pixel_queue.push_back(make_pixel(-524288, 524287, 524287));
      pixel_queue.push_back(make_pixel(0, 0, -524288));
      pixel_queue.push_back(make_pixel(1, 1, 1));
      pixel_queue.push_back(make_pixel(-1, -1, -1));
      pixel_queue.push_back(make_pixel(4, 4, 4));
      pixel_queue.push_back(make_pixel(12, 12, 13));
      pixel_queue.push_back(make_pixel(14, 14, 14));
      pixel_queue.push_back(make_pixel(4096, 4096, 4096));
      pixel_queue.push_back(make_pixel(1024, 2048, 512));
      pixel_queue.push_back(make_pixel(40960, 0, 0));
      pixel_queue.push_back(make_pixel(0, 40960, 0));
      pixel_queue.push_back(make_pixel(8192, 2000, -4000));
      pixel_queue.push_back(make_pixel(100, 50, 25));
      pixel_queue.push_back(make_pixel(262144, 262144, 1));
      wait_drain();

      write_gain(16'hFFFF);
      queue_random(300);
      wait_drain();

      write_gain(16'd0);
      pixel_queue.push_back(make_pixel(524287, 524287, 524287));
      queue_random(100);
      wait_drain();

      sender_idle_pct = 59;
      write_gain(16'($urandom_range(0, 65535)));
      queue_random(300);
      wait_drain();

      write_gain(16'($urandom_range(1024, 8192)));
      queue_random(200);
      wait_drain();

      sender_idle_pct = 0;
      write_gain(GAIN_RESET);
      pixel_queue.push_back(make_pixel(1, 2, 3));
      queue_random(300);
      wait_drain();

      $display("Sent %0d pixels over six gain settings, including zero and full scale;",
               pixels_sent);
      $display("checked %0d results, %0d mismatches.", pixels_checked, mismatch_count);
      if (mismatch_count == 0 && unexpected_count == 0 && expected_pixels.size() == 0) begin
         $display("tb_display_transform_pixel: clean");
      end else begin
         $display("tb_display_transform_pixel: errors");
      end
      $finish;
   end

   // Watchdog for a hung pipeline.
   initial begin
      #2000000;
      $display("timeout with %0d pixels outstanding", expected_pixels.size());
      $display("tb_display_transform_pixel: errors");
      $finish;
   end

endmodule
